// File: sv/pttt_pkg.sv
`default_nettype none

package pttt_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;
    localparam int OP_W        = 3;
    localparam int ID_W        = 3;
    localparam int PERIOD_W    = 32;
    localparam int TICK_W      = 32;
    localparam int STATUS_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_ENABLE     = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_RUN        = 3'd4,
        OP_TICK       = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_DUE     = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_rd;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic scan_last;
        logic emit_done;
    } t_stat;

endpackage

`default_nettype wire

// File: sv/pttt_if.sv
`default_nettype none

interface pttt_in_if import pttt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     slot_id;
    logic [PERIOD_W-1:0] period;
    logic                periodic;
    logic                handler_valid;

    modport source (output valid, op, slot_id, period, periodic, handler_valid,
                    input ready);
    modport sink   (input valid, op, slot_id, period, periodic, handler_valid,
                    output ready);
endinterface

interface pttt_out_if import pttt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     slot;
    logic                last;

    modport source (output valid, status, slot, last, input ready);
    modport sink   (input valid, status, slot, last, output ready);
endinterface

`default_nettype wire

// File: sv/pttt_ctrl.sv
`default_nettype none

module pttt_ctrl import pttt_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_in_is_run,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_in_is_run ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // The last slot read is evaluated in this cycle.
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/pttt_dp.sv
`default_nettype none

module pttt_dp import pttt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  wire [OP_W-1:0]       i_op,
    input  wire [ID_W-1:0]       i_slot_id,
    input  wire [PERIOD_W-1:0]   i_period,
    input  wire                  i_periodic,
    input  wire                  i_handler_valid,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ID_W-1:0]      o_slot,
    output logic                 o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW = PERIOD_W + TICK_W;

    // Latched input item.
    logic [OP_W-1:0]     r_op;
    logic [ID_W-1:0]     r_slot_id;
    logic [PERIOD_W-1:0] r_period;
    logic                r_periodic;
    logic                r_handler;

    logic [TICK_W-1:0]   r_now;
    logic [SLOTS-1:0]    r_used;
    logic [SLOTS-1:0]    r_en;
    logic [SLOTS-1:0]    r_rep;

    // Period and time stamp of each slot, {period, stamp}.
    logic [MW-1:0]       r_mem [SLOTS];
    logic [MW-1:0]       r_rdata;

    logic [IW-1:0]       r_idx;
    logic                r_eval_vld;
    logic [IW-1:0]       r_eval_ix;
    logic [CNT_W-1:0]    r_cnt;
    logic [SLOTS-1:0]    r_due;

    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ID_W-1:0]     r_o_slot;
    logic                r_o_last;

    logic                free_any;
    logic [IW-1:0]       free_ix;
    logic [IW-1:0]       due_ix;
    logic [IW-1:0]       id_ix;
    logic                id_ok;
    logic                reg_ok;
    logic [PERIOD_W-1:0] rd_period;
    logic [TICK_W-1:0]   rd_last;
    logic [TICK_W-1:0]   elapsed;
    logic                eval_hit;
    logic [SLOTS-1:0]    due_rest;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    logic [MW-1:0]       mem_wd;
    logic [STATUS_W-1:0] ex_status;
    logic [ID_W-1:0]     ex_slot;

    // Lowest free slot and lowest pending due slot.
    always_comb begin
        free_any = 1'b0;
        free_ix  = '0;
        due_ix   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_ix  = IW'(i);
            end
            if (r_due[i]) begin
                due_ix = IW'(i);
            end
        end
    end

    assign id_ok  = (32'(r_slot_id) < 32'(SLOTS));
    assign id_ix  = IW'(r_slot_id);
    assign reg_ok = r_handler && free_any;

    assign rd_period = r_rdata[MW-1:TICK_W];
    assign rd_last   = r_rdata[TICK_W-1:0];
    assign elapsed   = r_now - rd_last;
    assign eval_hit  = r_eval_vld && r_used[r_eval_ix] && r_en[r_eval_ix]
                       && (r_cnt < CNT_W'(MAX_RESULTS))
                       && ((rd_period == '0) || (elapsed >= rd_period));

    assign due_rest = r_due & (r_due - 1'b1);

    assign mem_we = (i_cmd.exec && (r_op == OP_REGISTER) && reg_ok) || eval_hit;
    assign mem_wa = eval_hit ? r_eval_ix : free_ix;
    assign mem_wd = eval_hit ? {rd_period, r_now} : {r_period, r_now};

    always_comb begin
        ex_status = ST_OK;
        ex_slot   = '0;
        unique case (r_op) inside
            OP_REGISTER: begin
                if (reg_ok) begin
                    ex_slot = ID_W'(free_ix);
                end else begin
                    ex_status = ST_REFUSED;
                end
            end
            OP_UNREGISTER, OP_ENABLE, OP_DISABLE: begin
                ex_slot = r_slot_id;
            end
            default: begin
                ex_slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_slot_id  <= i_slot_id;
            r_period   <= i_period;
            r_periodic <= i_periodic;
            r_handler  <= i_handler_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_used <= '0;
            r_en   <= '0;
            r_rep  <= '0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_op) inside
                    OP_REGISTER: begin
                        if (reg_ok) begin
                            r_used[free_ix] <= 1'b1;
                            r_en[free_ix]   <= 1'b1;
                            r_rep[free_ix]  <= r_periodic;
                        end
                    end
                    OP_UNREGISTER: begin
                        if (id_ok) begin
                            r_used[id_ix] <= 1'b0;
                        end
                    end
                    OP_ENABLE, OP_DISABLE: begin
                        if (id_ok && r_used[id_ix]) begin
                            r_en[id_ix] <= (r_op == OP_ENABLE);
                        end
                    end
                    OP_TICK: begin
                        r_now <= r_now + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            // A one-shot slot is released once it has fired.
            if (eval_hit && !r_rep[r_eval_ix]) begin
                r_used[r_eval_ix] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_eval_vld <= 1'b0;
            r_cnt      <= '0;
            r_due      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_cnt <= '0;
                r_due <= '0;
            end
            if (i_cmd.scan_rd) begin
                r_eval_vld <= 1'b1;
                if (r_idx != IW'(SLOTS - 1)) begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_eval_vld <= 1'b0;
            end
            if (eval_hit) begin
                r_due[r_eval_ix] <= 1'b1;
                r_cnt            <= r_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_due <= due_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_eval_ix <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_status <= ex_status;
            r_o_slot   <= ex_slot;
            r_o_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            if (r_due == '0) begin
                r_o_status <= ST_NONE;
                r_o_slot   <= '0;
                r_o_last   <= 1'b1;
            end else begin
                r_o_status <= ST_DUE;
                r_o_slot   <= ID_W'(due_ix);
                r_o_last   <= (due_rest == '0);
            end
        end
    end

    assign o_stat.out_free  = !r_o_valid || i_out_ready;
    assign o_stat.scan_last = (r_idx == IW'(SLOTS - 1));
    assign o_stat.emit_done = (due_rest == '0);

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_slot      = r_o_slot;
    assign o_last      = r_o_last;

`ifndef NO_ASSERTIONS
    a_due_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_due) <= MAX_RESULTS)
        else $error("more due slots pending than one scan may report");

    a_exec_not_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && r_eval_vld))
        else $error("single-item update overlaps a scan evaluation");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.emit) |-> (!r_o_valid || i_out_ready))
        else $error("result loaded over one not yet taken");

    a_register_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_REGISTER) && reg_ok) |=> r_used[$past(free_ix)])
        else $error("accepted register left its slot free");
`endif

endmodule

`default_nettype wire

// File: sv/periodic_task_timer_table_core.sv
// Non-scan items: one result, loaded once the output register is free after the input transfer;
// the next item is taken only after that result is loaded. Run scan: the slot table is read one
// slot per cycle from the stamp memory, then one result per cycle while the output is taken.
// Input is taken again as soon as the last result of an item sits in the output register.
// Reset is synchronous, active low: clears the time counter, slot flags and controller;
// the period and stamp memory is not cleared and needs no clearing pass.
`default_nettype none

module periodic_task_timer_table_core import pttt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pttt_in_if.sink     i_in,
    pttt_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    pttt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_is_run (i_in.op == OP_RUN),
        .o_in_ready  (i_in.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pttt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_in.op),
        .i_slot_id       (i_in.slot_id),
        .i_period        (i_in.period),
        .i_periodic      (i_in.periodic),
        .i_handler_valid (i_in.handler_valid),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_status        (o_out.status),
        .o_slot          (o_out.slot),
        .o_last          (o_out.last)
    );

endmodule

`default_nettype wire
